>>> rtl/core/sfpp_pkg.sv
// Shared constants, codes and the byte-wide CRC-16 step for the frame parser.
package sfpp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED    = 4'd3;

  // Verdict codes carried on error_code.
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CRC    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LENGTH = 2'd2;

  // Valid frame type range.
  localparam logic [BYTE_W-1:0] TYPE_MIN = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_MAX = 8'h04;

  // One byte folded into the CRC, most significant bit first.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/sync_framed_packet_parser.sv
// Top level of the sync-word framed packet parser with payload CRC-16 check.
// A received word is held in the input register, parsed from there, and its
// result word, if any, is then registered in the result register.
// Throughput: one word per cycle while the result side does not stall, set by the single parse stage.
// Reset (rst, synchronous, active high) restores register defaults, returns
// to the sync hunt and empties both the input and the result registers.
module sync_framed_packet_parser #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [sfpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfpp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Received byte stream.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sfpp_pkg::BYTE_W-1:0]          rx_byte,
  // Result words.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sfpp_pkg::BYTE_W-1:0]          payload_byte,
  output logic [sfpp_pkg::BYTE_W-1:0]          byte_index,
  output logic                                 last,
  output logic                                 frame_good,
  output logic [sfpp_pkg::ERR_W-1:0]           error_code,
  output logic [sfpp_pkg::TYPE_W-1:0]          frame_type,
  output logic [sfpp_pkg::BYTE_W-1:0]          sequence_res,
  output logic [sfpp_pkg::BYTE_W-1:0]          message_id,
  output logic [sfpp_pkg::LEN_W-1:0]           payload_length
);

  // Parser phases, in the order the header bytes arrive.
  localparam logic [3:0] PH_SYNC0   = 4'd0;
  localparam logic [3:0] PH_SYNC1   = 4'd1;
  localparam logic [3:0] PH_VERSION = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_SEQ     = 4'd4;
  localparam logic [3:0] PH_MSGID   = 4'd5;
  localparam logic [3:0] PH_LENLO   = 4'd6;
  localparam logic [3:0] PH_LENHI   = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CRCLO   = 4'd9;
  localparam logic [3:0] PH_CRCHI   = 4'd10;

  // Longest payload accepted without a length error.
  localparam logic [sfpp_pkg::LEN_W-1:0] MaxLen = sfpp_pkg::LEN_W'(MAX_PAYLOAD);

  // Configuration registers.
  logic [sfpp_pkg::BYTE_W-1:0] first_sync;
  logic [sfpp_pkg::BYTE_W-1:0] second_sync;
  logic [3:0]                  version_major;
  logic [sfpp_pkg::CRC_W-1:0]  crc_seed;

  // Input register.
  logic                        in_full;
  logic [sfpp_pkg::BYTE_W-1:0] in_byte;

  // Parser state.
  logic [3:0]                  phase, phase_next;
  logic [sfpp_pkg::LEN_W-1:0]  declared_length, declared_length_next;
  logic [sfpp_pkg::LEN_W-1:0]  bytes_seen, bytes_seen_next;
  logic [sfpp_pkg::CRC_W-1:0]  running_crc, running_crc_next;
  logic [sfpp_pkg::BYTE_W-1:0] crc_low, crc_low_next;
  logic [sfpp_pkg::TYPE_W-1:0] type_held, type_held_next;
  logic [sfpp_pkg::BYTE_W-1:0] sequence_held, sequence_held_next;
  logic [sfpp_pkg::BYTE_W-1:0] message_id_held, message_id_held_next;

  // Result word built in the parse stage.
  logic                        emit;
  logic [sfpp_pkg::BYTE_W-1:0] res_byte;
  logic [sfpp_pkg::BYTE_W-1:0] res_index;
  logic                        res_last;
  logic [sfpp_pkg::ERR_W-1:0]  res_err;

  logic                        advance;
  logic [sfpp_pkg::LEN_W-1:0]  seen_inc;
  logic [sfpp_pkg::CRC_W-1:0]  received_crc;

  // The parse stage moves whenever the result register is free or being
  // emptied in the same cycle; the input register refills behind it.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  assign seen_inc     = bytes_seen + sfpp_pkg::LEN_W'(1);
  assign received_crc = {in_byte, crc_low};

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync    <= 8'hAA;
      second_sync   <= 8'h55;
      version_major <= 4'h1;
      crc_seed      <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfpp_pkg::CFG_FIRST_SYNC:  first_sync    <= cfg_data[sfpp_pkg::BYTE_W-1:0];
        sfpp_pkg::CFG_SECOND_SYNC: second_sync   <= cfg_data[sfpp_pkg::BYTE_W-1:0];
        sfpp_pkg::CFG_VERSION:     version_major <= cfg_data[3:0];
        sfpp_pkg::CFG_CRC_SEED:    crc_seed      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Phase step and result selection for the byte in the input register.
  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    bytes_seen_next      = bytes_seen;
    running_crc_next     = running_crc;
    crc_low_next         = crc_low;
    type_held_next       = type_held;
    sequence_held_next   = sequence_held;
    message_id_held_next = message_id_held;
    emit                 = 1'b0;
    res_byte             = in_byte;
    res_index            = bytes_seen[sfpp_pkg::BYTE_W-1:0];
    res_last             = 1'b0;
    res_err              = sfpp_pkg::ERR_NONE;

    unique case (phase)
      PH_SYNC0: begin
        if (in_byte == first_sync) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_SYNC1: begin
        // A mismatching byte is not retried as a first sync byte.
        phase_next = (in_byte == second_sync) ? PH_VERSION : PH_SYNC0;
      end
      PH_VERSION: begin
        if (in_byte[7:4] != version_major) begin
          phase_next           = PH_SYNC0;
          declared_length_next = '0;
          bytes_seen_next      = '0;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (in_byte < sfpp_pkg::TYPE_MIN || in_byte > sfpp_pkg::TYPE_MAX) begin
          phase_next           = PH_SYNC0;
          declared_length_next = '0;
          bytes_seen_next      = '0;
        end else begin
          type_held_next = in_byte[sfpp_pkg::TYPE_W-1:0];
          phase_next     = PH_SEQ;
        end
      end
      PH_SEQ: begin
        sequence_held_next = in_byte;
        phase_next         = PH_MSGID;
      end
      PH_MSGID: begin
        message_id_held_next = in_byte;
        phase_next           = PH_LENLO;
      end
      PH_LENLO: begin
        declared_length_next = {8'h00, in_byte};
        phase_next           = PH_LENHI;
      end
      PH_LENHI: begin
        declared_length_next = {in_byte, declared_length[7:0]};
        bytes_seen_next      = '0;
        running_crc_next     = crc_seed;
        // An empty payload goes straight to the CRC bytes.
        phase_next = ({in_byte, declared_length[7:0]} == '0) ? PH_CRCLO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        emit             = 1'b1;
        running_crc_next = sfpp_pkg::crc16_byte(running_crc, in_byte);
        bytes_seen_next  = seen_inc;
        if (seen_inc == declared_length) begin
          phase_next = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_low_next = in_byte;
        phase_next   = PH_CRCHI;
      end
      PH_CRCHI: begin
        emit      = 1'b1;
        res_byte  = '0;
        res_index = '0;
        res_last  = 1'b1;
        // An over-long frame is reported ahead of a CRC mismatch.
        if (declared_length > MaxLen) begin
          res_err = sfpp_pkg::ERR_LENGTH;
        end else if (running_crc != received_crc) begin
          res_err = sfpp_pkg::ERR_CRC;
        end
        phase_next           = PH_SYNC0;
        declared_length_next = '0;
        bytes_seen_next      = '0;
      end
      default: begin
        phase_next           = PH_SYNC0;
        declared_length_next = '0;
        bytes_seen_next      = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC0;
      declared_length <= '0;
      bytes_seen      <= '0;
      running_crc     <= 16'hFFFF;
      crc_low         <= '0;
      type_held       <= '0;
      sequence_held   <= '0;
      message_id_held <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      bytes_seen      <= bytes_seen_next;
      running_crc     <= running_crc_next;
      crc_low         <= crc_low_next;
      type_held       <= type_held_next;
      sequence_held   <= sequence_held_next;
      message_id_held <= message_id_held_next;
    end
  end

  // Result register. The frame fields reflect the state as it stands when
  // the word is built, which for a verdict is before the hunt resets it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      payload_byte   <= res_byte;
      byte_index     <= res_index;
      last           <= res_last;
      frame_good     <= res_last && (res_err == sfpp_pkg::ERR_NONE);
      error_code     <= res_err;
      frame_type     <= type_held;
      sequence_res   <= sequence_held;
      message_id     <= message_id_held;
      payload_length <= declared_length;
    end
  end

endmodule

>>> rtl/core/sfpp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
module sfpp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sfpp_pkg::BYTE_W-1:0]      payload_byte,
  input logic [sfpp_pkg::BYTE_W-1:0]      byte_index,
  input logic                             last,
  input logic                             frame_good,
  input logic [sfpp_pkg::ERR_W-1:0]       error_code
);

  // A stalled result word holds its valid, byte, index, last and error code.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && out_valid && !out_ready |=> out_valid && $stable(payload_byte)
      && $stable(byte_index) && $stable(last) && $stable(error_code))
    else $error("result word changed while stalled");

  // A verdict is good exactly when it carries no error; its byte and index are cleared.
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (frame_good == (error_code == sfpp_pkg::ERR_NONE))
      && (payload_byte == '0) && (byte_index == '0))
    else $error("inconsistent verdict word");

  // Payload words carry no verdict.
  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !frame_good && (error_code == sfpp_pkg::ERR_NONE))
    else $error("payload word carries a verdict");

  // Only the defined error codes appear.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code == sfpp_pkg::ERR_NONE) || (error_code == sfpp_pkg::ERR_CRC)
      || (error_code == sfpp_pkg::ERR_LENGTH))
    else $error("undefined error code");

endmodule

bind sync_framed_packet_parser sfpp_checker u_sfpp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .byte_index   (byte_index),
  .last         (last),
  .frame_good   (frame_good),
  .error_code   (error_code)
);
